### rtl/core/scv_pkg.sv
`default_nettype none

package scv_pkg;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_APPEND = 3'd1;
   localparam logic [2:0] CMD_QUERY  = 3'd2;
   localparam logic [2:0] CMD_VGRAD  = 3'd3;
   localparam logic [2:0] CMD_IGRAD  = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned MAX_RESULTS = 32;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_QUERY,
      OP_VGRAD,
      OP_IGRAD,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] knot_x;
      logic signed [31:0] knot_y;
      logic               knot_unknown;
      logic signed [31:0] query_x;
      logic signed [31:0] multiplier;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value;
      logic signed [63:0] integral;
      logic [4:0]         grad_index;
      logic signed [63:0] grad_delta;
      logic               grad_valid;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/step_curve_value_integral_gradient.sv
`default_nettype none

// Step-curve knot table with value, integral and gradient queries. A command is
// taken into a two-entry queue and then carried out by a sequencer that owns the
// knot table, a RAM with a registered read. Queries walk the table from the first
// knot, passing each knot in four steps (table read, compare, multiply, saturate
// and accumulate); the table has a single read port and the steps share one
// multiplier. Each contribution of an integral gradient, up to MAX_RESULTS of
// them, is one transfer on the result channel, and the final transfer of a
// command carries rsp_last.
module step_curve_value_integral_gradient
   import scv_pkg::*;
#(
   parameter int MAX_KNOTS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [31:0] req_knot_x,
   input  wire logic signed [31:0] req_knot_y,
   input  wire logic               req_knot_unknown,
   input  wire logic signed [31:0] req_query_x,
   input  wire logic signed [31:0] req_multiplier,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_value,
   output logic signed [63:0]      rsp_integral,
   output logic [4:0]              rsp_grad_index,
   output logic signed [63:0]      rsp_grad_delta,
   output logic                    rsp_grad_valid,
   output logic                    rsp_last
);

   logic    push_valid;
   logic    push_ready;
   req_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   req_type pop_data;
   rsp_type rsp_data;

   scv_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_knot_x       (req_knot_x),
      .req_knot_y       (req_knot_y),
      .req_knot_unknown (req_knot_unknown),
      .req_query_x      (req_query_x),
      .req_multiplier   (req_multiplier),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   scv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   scv_back #(
      .MAX_KNOTS (MAX_KNOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last)
   );

   assign rsp_status     = rsp_data.status;
   assign rsp_value      = rsp_data.value;
   assign rsp_integral   = rsp_data.integral;
   assign rsp_grad_index = rsp_data.grad_index;
   assign rsp_grad_delta = rsp_data.grad_delta;
   assign rsp_grad_valid = rsp_data.grad_valid;

endmodule

`default_nettype wire

### rtl/core/scv_ram.sv
`default_nettype none

module scv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/scv_front.sv
`default_nettype none

module scv_front
   import scv_pkg::*;
(
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [31:0] req_knot_x,
   input  wire logic signed [31:0] req_knot_y,
   input  wire logic               req_knot_unknown,
   input  wire logic signed [31:0] req_query_x,
   input  wire logic signed [31:0] req_multiplier,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output req_type                 push_data
);

   op_type op;

   always_comb begin
      unique case (req_command)
         CMD_CLEAR:  op = OP_CLEAR;
         CMD_APPEND: op = OP_APPEND;
         CMD_QUERY:  op = OP_QUERY;
         CMD_VGRAD:  op = OP_VGRAD;
         CMD_IGRAD:  op = OP_IGRAD;
         default:    op = OP_NOP;
      endcase
   end

   assign push_valid             = req_valid;
   assign req_ready              = push_ready;
   assign push_data.op           = op;
   assign push_data.knot_x       = req_knot_x;
   assign push_data.knot_y       = req_knot_y;
   assign push_data.knot_unknown = req_knot_unknown;
   assign push_data.query_x      = req_query_x;
   assign push_data.multiplier   = req_multiplier;

endmodule

`default_nettype wire

### rtl/core/scv_queue.sv
`default_nettype none

module scv_queue
   import scv_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  req_type   push_data,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output req_type   pop_data
);

   req_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/core/scv_back.sv
`default_nettype none

module scv_back
   import scv_pkg::*;
#(
   parameter int MAX_KNOTS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic pop_valid,
   output logic      pop_ready,
   input  req_type   pop_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data,
   output logic      rsp_last
);

   localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
   localparam int CW = $clog2(MAX_KNOTS + 1);
   localparam int KW = 65;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EV, S_FN, S_MU, S_AC, S_DONE
   } state_type;

   function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
      logic signed [63:0] r;
      if (v[64] != v[63]) begin
         r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         r = v[63:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      return sat65(s);
   endfunction

   state_type          state_ff;
   req_type            cur_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic signed [31:0] px_ff;
   logic signed [31:0] py_ff;
   logic               pu_ff;
   logic               seg_u_ff;
   logic               fin_ff;
   logic signed [32:0] opa_ff;
   logic signed [31:0] opb_ff;
   logic signed [64:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic [CW-1:0]      rank_ff;
   logic [5:0]         nres_ff;
   rsp_type            pend_ff;
   logic               pend_valid_ff;
   rsp_type            out_ff;
   logic               out_last_ff;
   logic               out_valid_ff;
   logic               out_valid_in;

   logic               wr_en;
   logic [KW-1:0]      rd_data;
   logic signed [31:0] kx;
   logic signed [31:0] ky;
   logic               ku;
   logic signed [31:0] q;
   logic signed [31:0] m;
   logic               out_free;
   logic               full;
   logic               res_room;
   logic signed [63:0] sat_p;
   logic               emit_req;
   rsp_type            emit_data;
   rsp_type            grad_rsp;
   rsp_type            idle_rsp;
   logic               start_walk;

   scv_ram #(
      .WIDTH (KW),
      .DEPTH (MAX_KNOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({pop_data.knot_unknown, pop_data.knot_y, pop_data.knot_x}),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign kx        = rd_data[31:0];
   assign ky        = rd_data[63:32];
   assign ku        = rd_data[64];
   assign q         = cur_ff.query_x;
   assign m         = cur_ff.multiplier;
   assign full      = (count_ff == CW'(MAX_KNOTS));
   assign res_room  = (nres_ff < 6'(MAX_RESULTS));
   assign out_free  = !out_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == S_IDLE);
   assign wr_en     = (state_ff == S_IDLE) && pop_valid &&
                      (pop_data.op == OP_APPEND) && !full;
   assign sat_p     = sat65(prod_ff);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_last  = out_last_ff;

   // Status of a command that needs no table walk, decided as it is taken.
   always_comb begin
      idle_rsp   = '0;
      start_walk = 1'b0;
      case (pop_data.op)
         OP_APPEND: begin
            if (full) begin
               idle_rsp.status = ST_FULL;
            end
         end
         OP_QUERY, OP_VGRAD, OP_IGRAD: begin
            if (count_ff == '0) begin
               idle_rsp.status = ST_EMPTY;
            end else begin
               start_walk = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      grad_rsp            = '0;
      grad_rsp.status     = ST_OK;
      grad_rsp.grad_index = 5'(rank_ff);
      grad_rsp.grad_delta = sat_p;
      grad_rsp.grad_valid = 1'b1;
      emit_req            = 1'b0;
      emit_data           = grad_rsp;
      if (!fin_ff) begin
         emit_req = (cur_ff.op == OP_IGRAD) && seg_u_ff && res_room;
      end else begin
         case (cur_ff.op)
            OP_QUERY: begin
               emit_req           = 1'b1;
               emit_data          = '0;
               emit_data.value    = py_ff;
               emit_data.integral = sat_add(acc_ff, sat_p);
            end
            OP_VGRAD: begin
               emit_req = 1'b1;
               if (!pu_ff) begin
                  emit_data = '0;
               end
            end
            default: begin
               emit_req = pu_ff && res_room;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if ((state_ff == S_AC) && emit_req && pend_valid_ff && out_free) begin
         out_valid_in = 1'b1;
      end
      if ((state_ff == S_DONE) && out_free) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  cur_ff        <= pop_data;
                  idx_ff        <= '0;
                  rank_ff       <= '0;
                  nres_ff       <= '0;
                  acc_ff        <= '0;
                  pend_ff       <= idle_rsp;
                  pend_valid_ff <= (idle_rsp.status != ST_OK);
                  state_ff      <= start_walk ? S_RD : S_DONE;
                  if (pop_data.op == OP_CLEAR) begin
                     count_ff <= '0;
                  end else if (wr_en) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_EV;
            end
            S_EV: begin
               if (idx_ff == '0) begin
                  px_ff <= kx;
                  py_ff <= ky;
                  pu_ff <= ku;
                  // The integral gradient also stops on a query exactly at the first knot.
                  if (((cur_ff.op == OP_IGRAD) ? (kx >= q) : (kx > q)) ||
                      (count_ff == CW'(1))) begin
                     state_ff <= S_FN;
                  end else begin
                     idx_ff   <= CW'(1);
                     state_ff <= S_RD;
                  end
               end else if (kx > q) begin
                  state_ff <= S_FN;
               end else begin
                  opa_ff   <= {kx[31], kx} - {px_ff[31], px_ff};
                  opb_ff   <= (cur_ff.op == OP_QUERY) ? py_ff : m;
                  seg_u_ff <= pu_ff;
                  fin_ff   <= 1'b0;
                  px_ff    <= kx;
                  py_ff    <= ky;
                  pu_ff    <= ku;
                  state_ff <= S_MU;
               end
            end
            S_FN: begin
               // A value gradient scales the multiplier by one in Q16.16.
               opa_ff   <= (cur_ff.op == OP_VGRAD) ? 33'sd65536 :
                           ({q[31], q} - {px_ff[31], px_ff});
               opb_ff   <= (cur_ff.op == OP_QUERY) ? py_ff : m;
               fin_ff   <= 1'b1;
               state_ff <= S_MU;
            end
            S_MU: begin
               prod_ff  <= 65'(opa_ff) * 65'(opb_ff);
               state_ff <= S_AC;
            end
            S_AC: begin
               if (!(emit_req && pend_valid_ff && !out_free)) begin
                  if (emit_req) begin
                     if (pend_valid_ff) begin
                        out_ff      <= pend_ff;
                        out_last_ff <= 1'b0;
                     end
                     pend_ff       <= emit_data;
                     pend_valid_ff <= 1'b1;
                     nres_ff       <= nres_ff + 6'd1;
                  end
                  if (fin_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     if (cur_ff.op == OP_QUERY) begin
                        acc_ff <= sat_add(acc_ff, sat_p);
                     end
                     if (seg_u_ff) begin
                        rank_ff <= rank_ff + 1'b1;
                     end
                     if ((idx_ff + 1'b1) == count_ff) begin
                        state_ff <= S_FN;
                     end else begin
                        idx_ff   <= idx_ff + 1'b1;
                        state_ff <= S_RD;
                     end
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  out_ff        <= pend_valid_ff ? pend_ff : '0;
                  out_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
